>>> sv/dsvm_pkg.sv
`timescale 1ns / 1ps

package dsvm_pkg;

  // default sizing
  localparam int VOICES_DEFAULT   = 16;
  localparam int DRUMS_DEFAULT    = 8;
  localparam int SAMPLES_PER_DRUM = 16384;

  // field widths
  localparam int OP_W     = 2;
  localparam int MASK_W   = 8;
  localparam int SEL_W    = 3;
  localparam int ADDR_W   = 14;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 15;
  localparam int MIX_W    = 20;
  localparam int COUNT_W  = 4;

  // mix accumulator, wide enough for 64 full-scale voices
  localparam int ACC_W = 24;
  localparam logic signed [ACC_W-1:0] MIX_MAX = 24'sd524287;
  localparam logic signed [ACC_W-1:0] MIX_MIN = -24'sd524288;

  typedef enum logic [OP_W-1:0] {
    OP_TICK         = 2'd0,
    OP_TRIGGER      = 2'd1,
    OP_WRITE_SAMPLE = 2'd2,
    OP_WRITE_LENGTH = 2'd3
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic trig_step;
    logic mix_step;
    logic emit;
  } dsvm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dsvm_status_t;

endpackage

>>> sv/dsvm_if.sv
`timescale 1ns / 1ps

interface dsvm_in_if;
  logic                                valid;
  logic                                ready;
  logic [dsvm_pkg::OP_W-1:0]           operation;
  logic [dsvm_pkg::MASK_W-1:0]         drum_mask;
  logic [dsvm_pkg::SEL_W-1:0]          drum_select;
  logic [dsvm_pkg::ADDR_W-1:0]         sample_address;
  logic signed [dsvm_pkg::SAMPLE_W-1:0] sample_value;
  logic [dsvm_pkg::LEN_W-1:0]          length_value;
  logic                                play_backwards;

  modport source (
    output valid, operation, drum_mask, drum_select, sample_address, sample_value,
           length_value, play_backwards,
    input  ready
  );
  modport sink (
    input  valid, operation, drum_mask, drum_select, sample_address, sample_value,
           length_value, play_backwards,
    output ready
  );
endinterface

interface dsvm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dsvm_pkg::MIX_W-1:0]   mixed_sample;
  logic [dsvm_pkg::COUNT_W-1:0]        voices_started;
  logic [dsvm_pkg::COUNT_W-1:0]        voices_dropped;

  modport source (
    output valid, mixed_sample, voices_started, voices_dropped,
    input  ready
  );
  modport sink (
    input  valid, mixed_sample, voices_started, voices_dropped,
    output ready
  );
endinterface

>>> sv/drum_sample_voice_mixer.sv
`timescale 1ns / 1ps
// channel | dir | carries
// in_i    | in  | operation, drum_mask, drum_select, sample_address, sample_value,
//         |     | length_value, play_backwards
// out_o   | out | mixed_sample, voices_started, voices_dropped
//
// one item at a time; a tick reads one sample per voice over all VOICES voices, then drains,
// a trigger walks min(DRUMS, 8) drums (one drum per cycle), a load goes straight to its result
// it returns to idle for the next item as a result enters the output register
// a held result stalls only the completion of the following item
// reset clears voices and drum lengths at once; sample words stay undefined until written

module drum_sample_voice_mixer #(
  parameter int VOICES = dsvm_pkg::VOICES_DEFAULT,
  parameter int DRUMS  = dsvm_pkg::DRUMS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsvm_in_if.sink    in_i,
  dsvm_out_if.source out_o
);

  dsvm_pkg::dsvm_cmd_t    cmd;
  dsvm_pkg::dsvm_status_t status;

  // sequencing
  dsvm_ctrl #(
    .VOICES (VOICES),
    .DRUMS  (DRUMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // storage, mixing and result register
  dsvm_datapath #(
    .VOICES (VOICES),
    .DRUMS  (DRUMS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .operation_i      (in_i.operation),
    .drum_mask_i      (in_i.drum_mask),
    .drum_select_i    (in_i.drum_select),
    .sample_address_i (in_i.sample_address),
    .sample_value_i   (in_i.sample_value),
    .length_value_i   (in_i.length_value),
    .play_backwards_i (in_i.play_backwards),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .mixed_sample_o   (out_o.mixed_sample),
    .voices_started_o (out_o.voices_started),
    .voices_dropped_o (out_o.voices_dropped)
  );

`ifndef ASSERT_OFF
  // block goes busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken twice in a row");

  // a trigger can neither start nor drop more than eight drums
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ({1'b0, out_o.voices_started} + {1'b0, out_o.voices_dropped}) <= 5'd8)
    else $error("started plus dropped above eight");

  // a mix result never carries trigger counts
  a_mix_no_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.mixed_sample != '0)) |->
      (out_o.voices_started == '0) && (out_o.voices_dropped == '0))
    else $error("mix result with voice counts");
`endif

endmodule

>>> sv/dsvm_ctrl.sv
`timescale 1ns / 1ps

module dsvm_ctrl #(
  parameter int VOICES = dsvm_pkg::VOICES_DEFAULT,
  parameter int DRUMS  = dsvm_pkg::DRUMS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [dsvm_pkg::OP_W-1:0] in_op_i,
  output logic                      in_ready_o,
  input  dsvm_pkg::dsvm_status_t    status_i,
  output dsvm_pkg::dsvm_cmd_t       cmd_o
);

  localparam int CNT_MAX   = (VOICES > dsvm_pkg::MASK_W) ? VOICES : dsvm_pkg::MASK_W;
  localparam int CNT_W     = $clog2(CNT_MAX);
  localparam int TRIG_STEPS = (DRUMS < dsvm_pkg::MASK_W) ? DRUMS : dsvm_pkg::MASK_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIG,
    S_MIX,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  // commands follow the state
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.trig_step = (state_q == S_TRIG);
    cmd_o.mix_step  = (state_q == S_MIX);
    cmd_o.emit      = (state_q == S_DONE) && status_i.out_free;
  end

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            unique case (dsvm_pkg::op_e'(in_op_i))
              dsvm_pkg::OP_TICK:    state_q <= S_MIX;
              dsvm_pkg::OP_TRIGGER: state_q <= S_TRIG;
              dsvm_pkg::OP_WRITE_SAMPLE,
              dsvm_pkg::OP_WRITE_LENGTH: state_q <= S_DONE;
              default:              state_q <= S_DONE;
            endcase
          end
        end
        S_TRIG: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(TRIG_STEPS - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_MIX: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(VOICES - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/dsvm_datapath.sv
`timescale 1ns / 1ps

module dsvm_datapath #(
  parameter int VOICES = dsvm_pkg::VOICES_DEFAULT,
  parameter int DRUMS  = dsvm_pkg::DRUMS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dsvm_pkg::dsvm_cmd_t                  cmd_i,
  output dsvm_pkg::dsvm_status_t               status_o,
  input  logic [dsvm_pkg::OP_W-1:0]            operation_i,
  input  logic [dsvm_pkg::MASK_W-1:0]          drum_mask_i,
  input  logic [dsvm_pkg::SEL_W-1:0]           drum_select_i,
  input  logic [dsvm_pkg::ADDR_W-1:0]          sample_address_i,
  input  logic signed [dsvm_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [dsvm_pkg::LEN_W-1:0]           length_value_i,
  input  logic                                 play_backwards_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [dsvm_pkg::MIX_W-1:0]    mixed_sample_o,
  output logic [dsvm_pkg::COUNT_W-1:0]         voices_started_o,
  output logic [dsvm_pkg::COUNT_W-1:0]         voices_dropped_o
);

  localparam int DRUM_W    = (DRUMS > 1) ? $clog2(DRUMS) : 1;
  localparam int MEM_AW    = DRUM_W + dsvm_pkg::ADDR_W;
  localparam int MEM_DEPTH = DRUMS * dsvm_pkg::SAMPLES_PER_DRUM;
  localparam int LEN_W     = dsvm_pkg::LEN_W;
  localparam int ACC_W     = dsvm_pkg::ACC_W;
  localparam int SAMPLE_W  = dsvm_pkg::SAMPLE_W;

  // captured item
  dsvm_pkg::op_e               op_q;
  logic                        back_q;
  logic [dsvm_pkg::MASK_W-1:0] mask_q;
  logic [dsvm_pkg::SEL_W-1:0]  drum_idx_q;

  // voice state, walked as a ring during a tick
  logic [VOICES-1:0]   busy_q;
  logic [LEN_W-1:0]    pos_q   [VOICES];
  logic [DRUM_W-1:0]   vdrum_q [VOICES];

  logic [LEN_W-1:0]    len_tab_q [DRUMS];

  logic signed [SAMPLE_W-1:0] sample_mem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       pend_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [dsvm_pkg::COUNT_W-1:0] started_q;
  logic [dsvm_pkg::COUNT_W-1:0] dropped_q;
  logic                         out_valid_q;

  // load decode
  logic             sel_ok;
  logic             we_sample;
  logic             we_length;
  logic [LEN_W-1:0] len_sat;
  logic [MEM_AW-1:0] waddr;

  assign sel_ok    = ({29'd0, drum_select_i} < 32'(DRUMS));
  assign we_sample = cmd_i.capture && sel_ok &&
                     (dsvm_pkg::op_e'(operation_i) == dsvm_pkg::OP_WRITE_SAMPLE);
  assign we_length = cmd_i.capture && sel_ok &&
                     (dsvm_pkg::op_e'(operation_i) == dsvm_pkg::OP_WRITE_LENGTH);
  assign len_sat   = (length_value_i > LEN_W'(dsvm_pkg::SAMPLES_PER_DRUM)) ?
                     LEN_W'(dsvm_pkg::SAMPLES_PER_DRUM) : length_value_i;
  assign waddr     = {DRUM_W'(drum_select_i), sample_address_i};

  // head voice of the ring
  logic              busy_h;
  logic [LEN_W-1:0]  pos_h;
  logic [DRUM_W-1:0] drum_h;
  logic [LEN_W-1:0]  len_h;
  logic              hit_h;
  logic              adv_h;
  logic [LEN_W-1:0]  idx_h;
  logic [MEM_AW-1:0] raddr;

  assign busy_h = busy_q[0];
  assign pos_h  = pos_q[0];
  assign drum_h = vdrum_q[0];
  assign len_h  = len_tab_q[drum_h];
  assign hit_h  = busy_h && (pos_h < len_h);
  assign adv_h  = (pos_h <= len_h);
  assign idx_h  = back_q ? (len_h - LEN_W'(1) - pos_h) : pos_h;
  assign raddr  = {drum_h, idx_h[dsvm_pkg::ADDR_W-1:0]};

  // lowest free voice
  logic [VOICES-1:0] free_v;
  logic [VOICES-1:0] pick_v;
  logic              any_free;

  assign free_v   = ~busy_q;
  assign pick_v   = free_v & (~free_v + VOICES'(1));
  assign any_free = |free_v;

  // sample memory
  always_ff @(posedge clk_i) begin
    if (we_sample) begin
      sample_mem[waddr] <= sample_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix_step) begin
      rdata_q <= sample_mem[raddr];
    end
  end

  // drum lengths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DRUMS; i++) begin
        len_tab_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < DRUMS; i++) begin
        if (we_length && (32'(drum_select_i) == i)) begin
          len_tab_q[i] <= len_sat;
        end
      end
    end
  end

  // captured item fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= dsvm_pkg::op_e'(operation_i);
      back_q <= play_backwards_i;
    end
  end

  // voices: claim on trigger, rotate and advance on tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      mask_q     <= '0;
      drum_idx_q <= '0;
      started_q  <= '0;
      dropped_q  <= '0;
      for (int p = 0; p < VOICES; p++) begin
        pos_q[p]   <= '0;
        vdrum_q[p] <= '0;
      end
    end else if (cmd_i.capture) begin
      mask_q     <= drum_mask_i;
      drum_idx_q <= '0;
      started_q  <= '0;
      dropped_q  <= '0;
    end else if (cmd_i.trig_step) begin
      mask_q     <= mask_q >> 1;
      drum_idx_q <= drum_idx_q + 1'b1;
      if (mask_q[0]) begin
        if (any_free) begin
          started_q <= started_q + 1'b1;
          for (int p = 0; p < VOICES; p++) begin
            if (pick_v[p]) begin
              busy_q[p]  <= 1'b1;
              pos_q[p]   <= '0;
              vdrum_q[p] <= DRUM_W'(drum_idx_q);
            end
          end
        end else begin
          dropped_q <= dropped_q + 1'b1;
        end
      end
    end else if (cmd_i.mix_step) begin
      for (int p = 0; p < VOICES - 1; p++) begin
        busy_q[p]  <= busy_q[p+1];
        pos_q[p]   <= pos_q[p+1];
        vdrum_q[p] <= vdrum_q[p+1];
      end
      busy_q[VOICES-1]  <= busy_h & adv_h;
      pos_q[VOICES-1]   <= adv_h ? (pos_h + LEN_W'(1)) : pos_h;
      vdrum_q[VOICES-1] <= drum_h;
    end
  end

  // mix accumulator, one read behind the walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      pend_q <= cmd_i.mix_step && hit_h;
      if (cmd_i.capture) begin
        acc_q <= '0;
      end else if (pend_q) begin
        acc_q <= acc_q + {{(ACC_W-SAMPLE_W){rdata_q[SAMPLE_W-1]}}, rdata_q};
      end
    end
  end

  // result formatting
  logic signed [ACC_W-1:0]          acc_sat;
  logic signed [dsvm_pkg::MIX_W-1:0] mix_n;
  logic [dsvm_pkg::COUNT_W-1:0]     started_n;
  logic [dsvm_pkg::COUNT_W-1:0]     dropped_n;

  always_comb begin
    if (acc_q > dsvm_pkg::MIX_MAX) begin
      acc_sat = dsvm_pkg::MIX_MAX;
    end else if (acc_q < dsvm_pkg::MIX_MIN) begin
      acc_sat = dsvm_pkg::MIX_MIN;
    end else begin
      acc_sat = acc_q;
    end
    mix_n     = '0;
    started_n = '0;
    dropped_n = '0;
    case (op_q)
      dsvm_pkg::OP_TICK:    mix_n = acc_sat[dsvm_pkg::MIX_W-1:0];
      dsvm_pkg::OP_TRIGGER: begin
        started_n = started_q;
        dropped_n = dropped_q;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mixed_sample_o   <= mix_n;
      voices_started_o <= started_n;
      voices_dropped_o <= dropped_n;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule
